// ===== design/assert_macros.svh =====
// Assertion macros shared by the base-85 encoder RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every clock edge out of reset.
`define B85_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("%m: assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define B85_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define B85_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ===== design/b85_pkg.sv =====
// Types, constants and the digit alphabet of the base-85 stream encoder.
// No dependencies; every design module imports this package.
`default_nettype none

package b85_pkg;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_GT    = 8'h3E;

  localparam int unsigned NUM_DIG = 5;
  localparam logic [2:0] NDIG_FULL = 3'd5;
  localparam logic [2:0] NDIG_NONE = 3'd0;

  // floor(x / 85) == (x * RECIP) >> RECIP_SHIFT for every 32-bit x
  localparam logic [31:0] RECIP       = 32'd3233857729;
  localparam int unsigned RECIP_SHIFT = 38;
  localparam int unsigned QUO_W       = 64 - RECIP_SHIFT;
  localparam logic [6:0]  BASE        = 7'd85;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
  } out_t;

  // One request per input byte that produces text
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  ndig;
    logic        msg_open;
    logic        msg_close;
  } job_t;

  typedef logic [NUM_DIG-1:0][6:0] digits_t;

  // Digits ready for output, most significant at index 0
  typedef struct packed {
    digits_t    digits;
    logic [2:0] ndig;
    logic       msg_open;
    logic       msg_close;
  } pkt_t;

  function automatic logic [7:0] b85_char(input logic [6:0] d);
    logic [7:0] c;
    c = 8'h3F;
    if (d < 7'd10) begin
      c = 8'h30 + {1'b0, d};
    end else if (d < 7'd36) begin
      c = 8'h41 + {1'b0, d} - 8'd10;
    end else if (d < 7'd62) begin
      c = 8'h61 + {1'b0, d} - 8'd36;
    end else begin
      unique case (d)
        7'd62:   c = 8'h21;
        7'd63:   c = 8'h23;
        7'd64:   c = 8'h24;
        7'd65:   c = 8'h25;
        7'd66:   c = 8'h26;
        7'd67:   c = 8'h28;
        7'd68:   c = 8'h29;
        7'd69:   c = 8'h2A;
        7'd70:   c = 8'h2B;
        7'd71:   c = 8'h2D;
        7'd72:   c = 8'h3B;
        7'd73:   c = 8'h3C;
        7'd74:   c = 8'h3D;
        7'd75:   c = 8'h3E;
        7'd76:   c = 8'h3F;
        7'd77:   c = 8'h40;
        7'd78:   c = 8'h5E;
        7'd79:   c = 8'h5F;
        7'd80:   c = 8'h60;
        7'd81:   c = 8'h7B;
        7'd82:   c = 8'h7C;
        7'd83:   c = 8'h7D;
        7'd84:   c = 8'h7E;
        default: c = 8'h3F;
      endcase
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/b85_front.sv =====
// Front end: accepts message bytes, packs groups and issues conversion requests.
// Depends on b85_pkg.
`default_nettype none

module b85_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire b85_pkg::in_t  in_data,
  output logic               push,
  output b85_pkg::job_t      push_job,
  input  wire logic          q_ready
);
  import b85_pkg::*;

  logic [23:0] group_r;
  logic [1:0]  count_r;
  logic        in_msg_r;
  logic        accept;
  logic        grp_full;
  logic [7:0]  b;

  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;
  assign b        = in_data.data_byte;
  assign grp_full = (count_r == 2'd3);

  always_comb begin
    push_job.msg_open  = !in_msg_r;
    push_job.msg_close = in_data.is_last;
    push_job.word      = 32'd0;
    push_job.ndig      = NDIG_NONE;
    if (grp_full) begin
      push_job.word = {group_r, b};
      push_job.ndig = NDIG_FULL;
    end else if (in_data.is_last) begin
      // pad the partial group with zero bytes on the right
      unique case (count_r)
        2'd0:    push_job.word = {b, 24'd0};
        2'd1:    push_job.word = {group_r[7:0], b, 16'd0};
        2'd2:    push_job.word = {group_r[15:0], b, 8'd0};
        default: push_job.word = {group_r, b};
      endcase
      push_job.ndig = {1'b0, count_r} + 3'd2;
    end
  end

  assign push = accept && (!in_msg_r || grp_full || in_data.is_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_r  <= '0;
      count_r  <= '0;
      in_msg_r <= 1'b0;
    end else if (accept) begin
      priority if (in_data.is_last) begin
        group_r  <= '0;
        count_r  <= '0;
        in_msg_r <= 1'b0;
      end else if (grp_full) begin
        group_r  <= '0;
        count_r  <= '0;
        in_msg_r <= 1'b1;
      end else begin
        group_r  <= {group_r[15:0], b};
        count_r  <= count_r + 2'd1;
        in_msg_r <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/b85_queue.sv =====
// Short first-word-fall-through queue of conversion requests.
// Depends on b85_pkg.
`default_nettype none

module b85_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire b85_pkg::job_t  push_job,
  output logic                q_ready,
  output logic                q_valid,
  output b85_pkg::job_t       q_job,
  input  wire logic           pop
);
  import b85_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push;
  logic          do_pop;

  assign q_ready = (count_r != CW'(DEPTH));
  assign q_valid = (count_r != '0);
  assign q_job   = mem[rd_ptr_r];
  assign do_push = push && q_ready;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + CW'(1);
        2'b01:   count_r <= count_r - CW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/b85_divider.sv =====
// Back end, first half: turns a request word into base-85 digits, one
// division by 85 per cycle, rounding up partial groups. Depends on b85_pkg.
`default_nettype none
`include "assert_macros.svh"

module b85_divider (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_valid,
  input  wire b85_pkg::job_t  q_job,
  output logic                q_pop,
  output logic                pkt_valid,
  output b85_pkg::pkt_t       pkt,
  input  wire logic           pkt_take
);
  import b85_pkg::*;

  logic             run_r;
  logic [2:0]       step_r;
  logic [31:0]      x_r;
  logic             sticky_r;
  logic [2:0]       ndig_r;
  logic             open_r;
  logic             close_r;
  digits_t          dig_r;
  logic             pkt_v_r;
  pkt_t             pkt_r;

  logic [63:0]      prod;
  logic [QUO_W-1:0] quo;
  logic [6:0]       rem;
  logic [2:0]       drop;
  logic             dropping;
  logic             drop_end;
  logic             round_up;
  logic [31:0]      x_nxt;
  digits_t          dig_nxt;
  logic             done;
  logic             slot;

  assign prod     = {32'd0, x_r} * {32'd0, RECIP};
  assign quo      = prod[63:RECIP_SHIFT];
  assign rem      = x_r[6:0] - 7'(quo[6:0] * BASE);
  assign drop     = NDIG_FULL - ndig_r;
  assign dropping = (step_r < drop);
  assign drop_end = (drop != 3'd0) && (step_r == drop - 3'd1);
  // round up when any dropped digit was nonzero
  assign round_up = drop_end && (sticky_r || (rem != 7'd0));
  assign x_nxt    = 32'(quo) + {31'd0, round_up};
  assign dig_nxt  = dropping ? dig_r : {dig_r[NUM_DIG-2:0], rem};

  assign done      = run_r && ((ndig_r == NDIG_NONE) || (step_r == 3'(NUM_DIG - 1)));
  assign slot      = !pkt_v_r || pkt_take;
  assign q_pop     = !run_r && q_valid;
  assign pkt_valid = pkt_v_r;
  assign pkt       = pkt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= 1'b0;
      step_r  <= '0;
      pkt_v_r <= 1'b0;
    end else begin
      priority if (q_pop) begin
        run_r  <= 1'b1;
        step_r <= '0;
      end else if (done) begin
        if (slot) begin
          run_r <= 1'b0;
        end
      end else if (run_r) begin
        step_r <= step_r + 3'd1;
      end
      priority if (done && slot) begin
        pkt_v_r <= 1'b1;
      end else if (pkt_take) begin
        pkt_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      x_r      <= q_job.word;
      ndig_r   <= q_job.ndig;
      open_r   <= q_job.msg_open;
      close_r  <= q_job.msg_close;
      sticky_r <= 1'b0;
    end else if (run_r && !done) begin
      x_r      <= x_nxt;
      dig_r    <= dig_nxt;
      sticky_r <= sticky_r || (dropping && (rem != 7'd0));
    end
    if (done && slot) begin
      pkt_r.digits    <= dig_nxt;
      pkt_r.ndig      <= ndig_r;
      pkt_r.msg_open  <= open_r;
      pkt_r.msg_close <= close_r;
    end
  end

  `B85_ASSERT_NXT(a_pop_starts_run, q_pop, run_r && (step_r == 3'd0))
  `B85_ASSERT_IMP(a_ndig_legal, run_r, (ndig_r != 3'd1) && (ndig_r <= NDIG_FULL))
  `B85_ASSERT_NXT(a_pkt_held, pkt_v_r && !pkt_take, pkt_v_r && $stable(pkt_r))

endmodule

`default_nettype wire

// ===== design/b85_emit.sv =====
// Back end, second half: sends the wrapper and digit characters of each packet
// one per cycle through the output register while out_ready allows. Depends on b85_pkg.
`default_nettype none
`include "assert_macros.svh"

module b85_emit (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           pkt_valid,
  input  wire b85_pkg::pkt_t  pkt,
  output logic                pkt_take,
  output logic                out_valid,
  input  wire logic           out_ready,
  output b85_pkg::out_t       out_data
);
  import b85_pkg::*;

  logic [3:0] c_r;
  logic       out_v_r;
  out_t       out_r;

  logic [3:0] open_n;
  logic [3:0] close_n;
  logic [3:0] seq_len;
  logic [3:0] d;
  logic [3:0] e;
  logic       last;
  logic       adv;
  logic [7:0] ch;

  assign open_n  = pkt.msg_open ? 4'd2 : 4'd0;
  assign close_n = pkt.msg_close ? 4'd2 : 4'd0;
  assign seq_len = open_n + {1'b0, pkt.ndig} + close_n;
  assign d       = c_r - open_n;
  assign e       = d - {1'b0, pkt.ndig};
  assign last    = (c_r == seq_len - 4'd1);
  assign adv     = pkt_valid && (!out_v_r || out_ready);
  assign pkt_take = adv && last;

  always_comb begin
    priority if (c_r < open_n) begin
      ch = c_r[0] ? CH_TILDE : CH_LT;
    end else if (d < {1'b0, pkt.ndig}) begin
      ch = b85_char(pkt.digits[d[2:0]]);
    end else begin
      ch = (e == 4'd0) ? CH_TILDE : CH_GT;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r     <= '0;
      out_v_r <= 1'b0;
    end else begin
      priority if (adv) begin
        out_v_r <= 1'b1;
        c_r     <= last ? 4'd0 : c_r + 4'd1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.out_char <= ch;
      out_r.run_last <= last;
    end
  end

  `B85_ASSERT_IMP(a_idx_in_range, pkt_valid, c_r < seq_len)
  `B85_ASSERT_IMP(a_mid_needs_pkt, c_r != 4'd0, pkt_valid)
  `B85_ASSERT_NXT(a_take_rewinds, pkt_take, (c_r == 4'd0) && out_v_r && out_r.run_last)

endmodule

`default_nettype wire

// ===== design/base85_encoder_stream_top.sv =====
// A byte that completes a group or closes a message goes through the queue, five
// divide-by-85 steps and the packet and output registers; a byte that only opens a
// message needs no divide steps. Bytes are accepted one a cycle while the queue has room;
// the divider finishes each request before taking the next; the output sends one character
// a cycle unless out_ready stalls. Synchronous active-low reset clears all control state
// and starts a new message. Depends on b85_pkg and the four stage modules.
`default_nettype none

module base85_encoder_stream_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire b85_pkg::in_t   in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output b85_pkg::out_t       out_data
);
  import b85_pkg::*;

  logic  push;
  job_t  push_job;
  logic  q_ready;
  logic  q_valid;
  job_t  q_job;
  logic  q_pop;
  logic  pkt_valid;
  pkt_t  pkt;
  logic  pkt_take;

  b85_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .push     (push),
    .push_job (push_job),
    .q_ready  (q_ready)
  );

  b85_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .q_ready  (q_ready),
    .q_valid  (q_valid),
    .q_job    (q_job),
    .pop      (q_pop)
  );

  b85_divider u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .q_pop     (q_pop),
    .pkt_valid (pkt_valid),
    .pkt       (pkt),
    .pkt_take  (pkt_take)
  );

  b85_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .pkt_valid (pkt_valid),
    .pkt       (pkt),
    .pkt_take  (pkt_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== verif/tb_base85_encoder_stream_top.sv =====
// Self-checking testbench for base85_encoder_stream_top: byte messages in, wrapped base-85 text out.
// Needs b85_pkg (request/result structs, wrapper characters) and the encoder RTL; nothing else.
`default_nettype none

module tb_base85_encoder_stream_top;
  timeunit 1ns;
  timeprecision 1ps;

  import b85_pkg::*;

  localparam int unsigned ITEMS_RANDOM = 185;
  localparam int unsigned DRAIN_CYCLES = 30;

  localparam longint unsigned POW85 [0:4] = '{1, 85, 7225, 614125, 52200625};
  // digits 62..84 of the alphabet
  localparam logic [7:0] PUNCT [0:22] = '{
    8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2D, 8'h3B, 8'h3C,
    8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h5E, 8'h5F, 8'h60, 8'h7B, 8'h7C, 8'h7D, 8'h7E
  };

  typedef struct {
    logic [7:0] data_byte;
    logic       is_last;
    bit         typed;
    string      text;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  // encoder state mirrored by the predictor
  logic [23:0] enc_group;
  logic [1:0]  enc_count;
  logic        enc_open;

  logic [7:0] pend_chars [0:9];
  int         pend_n;
  out_t       exp_chars [$];
  stim_row_t  stim_table [$];

  int err_count;
  int n_msgs;
  int n_bytes;
  int n_chars;

  base85_encoder_stream_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] digit_char(input int unsigned d);
    if (d < 10) begin
      return 8'(8'h30 + d);
    end else if (d < 36) begin
      return 8'(8'h41 + d - 10);
    end else if (d < 62) begin
      return 8'(8'h61 + d - 36);
    end
    return PUNCT[d - 62];
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 25);
  endfunction

  task automatic add_char(input logic [7:0] c);
    pend_chars[pend_n] = c;
    pend_n++;
  endtask

  task automatic add_digits(input longint unsigned q, input int ndig);
    for (int i = ndig - 1; i >= 0; i--) begin
      add_char(digit_char(int'((q / POW85[i]) % 85)));
    end
  endtask

  // Work out the characters one accepted byte causes and advance the mirrored state.
  task automatic encode_byte(input in_t req);
    longint unsigned padded;
    longint unsigned divisor;
    longint unsigned q;
    int k;
    pend_n = 0;
    if (!enc_open) begin
      add_char(CH_LT);
      add_char(CH_TILDE);
      enc_open = 1'b1;
    end
    if (enc_count == 2'd3) begin
      add_digits({32'd0, enc_group, req.data_byte}, 5);
      enc_group = '0;
      enc_count = '0;
    end else begin
      enc_group = {enc_group[15:0], req.data_byte};
      enc_count = enc_count + 2'd1;
    end
    if (req.is_last) begin
      k = int'(enc_count);
      if (k != 0) begin
        padded  = {40'd0, enc_group} << (8 * (4 - k));
        divisor = POW85[4 - k];
        q = padded / divisor;
        // round up when any dropped digit is nonzero
        if (padded % divisor != 0) begin
          q++;
        end
        add_digits(q, k + 1);
      end
      add_char(CH_TILDE);
      add_char(CH_GT);
      enc_group = '0;
      enc_count = '0;
      enc_open  = 1'b0;
    end
  endtask

  task automatic queue_expected();
    out_t e;
    for (int i = 0; i < pend_n; i++) begin
      e.out_char = pend_chars[i];
      e.run_last = (i == pend_n - 1);
      exp_chars.push_back(e);
    end
  endtask

  task automatic add_row(input logic [7:0] b, input logic last, input bit typed,
                         input string text);
    stim_row_t row;
    row.data_byte = b;
    row.is_last   = last;
    row.typed     = typed;
    row.text      = text;
    stim_table.push_back(row);
  endtask

  // Present one request after a gap, hold it until accepted, then record what it should produce.
  task automatic send_req(input in_t req, input int unsigned gap, input bit typed,
                          input string text);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    encode_byte(req);
    if (typed) begin
      pend_n = text.len();
      for (int i = 0; i < pend_n; i++) begin
        pend_chars[i] = text[i];
      end
    end
    queue_expected();
    n_bytes++;
    if (req.is_last) begin
      n_msgs++;
    end
  endtask

  // Result side: random stalls, with occasional long stretches of steady ready.
  initial begin
    out_ready = 1'b0;
    forever begin
      int unsigned hold;
      hold = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 8);
      @(negedge clk);
      out_ready <= 1'b1;
      repeat (hold - 1) @(negedge clk);
      hold = pick_gap();
      if (hold > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (hold - 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (exp_chars.size() == 0) begin
        $error("unexpected character %h (run_last %b)", out_data.out_char, out_data.run_last);
        err_count++;
      end else begin
        out_t e;
        e = exp_chars.pop_front();
        n_chars++;
        if (out_data.out_char !== e.out_char) begin
          $error("out_char: expected %h, got %h", e.out_char, out_data.out_char);
          err_count++;
        end
        if (out_data.run_last !== e.run_last) begin
          $error("run_last: expected %b, got %b", e.run_last, out_data.run_last);
          err_count++;
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("base85_encoder_stream_top test failed");
    $finish;
  end

  initial begin
    in_t req;
    int unsigned len;
    int unsigned r;
    bit burst;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    enc_group = '0;
    enc_count = '0;
    enc_open  = 1'b0;
    err_count = 0;
    n_msgs    = 0;
    n_bytes   = 0;
    n_chars   = 0;

    // data, last, typed, expected text of that row
    add_row(8'h00, 1'b1, 1'b1, "<~00~>");
    add_row(8'h00, 1'b0, 1'b1, "<~");
    add_row(8'h00, 1'b0, 1'b1, "");
    add_row(8'h00, 1'b0, 1'b1, "");
    add_row(8'h00, 1'b1, 1'b1, "00000~>");
    add_row(8'hFF, 1'b1, 1'b0, "");
    add_row(8'h01, 1'b1, 1'b0, "");
    add_row(8'hFF, 1'b0, 1'b0, "");
    add_row(8'hFF, 1'b1, 1'b0, "");
    add_row(8'hFF, 1'b0, 1'b0, "");
    add_row(8'hFF, 1'b0, 1'b0, "");
    add_row(8'hFF, 1'b1, 1'b0, "");
    add_row(8'hFF, 1'b0, 1'b0, "");
    add_row(8'hFF, 1'b0, 1'b0, "");
    add_row(8'hFF, 1'b0, 1'b0, "");
    add_row(8'hFF, 1'b1, 1'b0, "");
    add_row(8'h80, 1'b0, 1'b0, "");
    add_row(8'h55, 1'b0, 1'b0, "");
    add_row(8'hAA, 1'b0, 1'b0, "");
    add_row(8'h7F, 1'b0, 1'b0, "");
    add_row(8'h01, 1'b1, 1'b0, "");

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (stim_table[i]) begin
      req.data_byte = stim_table[i].data_byte;
      req.is_last   = stim_table[i].is_last;
      send_req(req, pick_gap(), stim_table[i].typed, stim_table[i].text);
    end

    // random messages, mostly short, some long, some single bytes
    while (n_bytes < stim_table.size() + ITEMS_RANDOM) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        len = $urandom_range(2, 8);
      end else if (r < 85) begin
        len = $urandom_range(9, 24);
      end else begin
        len = 1;
      end
      burst = ($urandom_range(0, 3) == 0);
      for (int unsigned j = 0; j < len; j++) begin
        r = $urandom_range(0, 99);
        if (r < 12) begin
          req.data_byte = 8'h00;
        end else if (r < 24) begin
          req.data_byte = 8'hFF;
        end else begin
          req.data_byte = 8'($urandom_range(0, 255));
        end
        req.is_last = (j == len - 1);
        send_req(req, burst ? 0 : pick_gap(), 1'b0, "");
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;

    while (exp_chars.size() != 0) begin
      @(posedge clk);
    end
    // give any stray output a chance to show up
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Encoded %0d messages, %0d bytes in total, and checked %0d output characters.",
             n_msgs, n_bytes, n_chars);
    if (err_count == 0) begin
      $display("base85_encoder_stream_top test passed");
    end else begin
      $display("base85_encoder_stream_top test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
